### rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg - datetime string validator shared definitions
// Error codes, parse positions and the per-position pattern tables.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned VAL_W   = 7;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned SCALE_W = 3;

    localparam logic [POS_W-1:0] POS_SPACES     = 5'd10;
    localparam logic [POS_W-1:0] POS_TIME_FIRST = 5'd11;
    localparam logic [POS_W-1:0] POS_TIME_LAST  = 5'd18;
    localparam logic [POS_W-1:0] POS_DOTS       = 5'd19;
    localparam logic [POS_W-1:0] POS_FRAC       = 5'd20;

    localparam logic [CNT_W-1:0]   MAX_FRAC      = 3'd6;
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 3'd6;

    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DIGIT = 8'h00;  // table mark: a digit goes here

    localparam logic [VAL_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [VAL_W-1:0] DAY_MAX    = 7'd31;
    localparam logic [VAL_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [VAL_W-1:0] MINSEC_MAX = 7'd59;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_FORMAT,
        ERR_MONTH,
        ERR_DAY,
        ERR_HOUR,
        ERR_MINUTE,
        ERR_SECOND,
        ERR_FRACTION
    } dsv_err_t;

    typedef enum logic [2:0] {
        DEST_NONE,
        DEST_MONTH,
        DEST_DAY,
        DEST_HOUR,
        DEST_MINUTE,
        DEST_SECOND
    } dsv_dest_t;

    // Expected separator at a fixed-pattern position, CH_DIGIT where a digit goes.
    function automatic logic [CHAR_W-1:0] sep_at(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] s;
        case (pos)
            5'd4, 5'd7:   s = CH_DASH;
            5'd13, 5'd16: s = CH_COLON;
            default:      s = CH_DIGIT;
        endcase
        return s;
    endfunction

    function automatic dsv_dest_t dest_at(input logic [POS_W-1:0] pos);
        dsv_dest_t d;
        case (pos)
            5'd5, 5'd6:   d = DEST_MONTH;
            5'd8, 5'd9:   d = DEST_DAY;
            5'd11, 5'd12: d = DEST_HOUR;
            5'd14, 5'd15: d = DEST_MINUTE;
            5'd17, 5'd18: d = DEST_SECOND;
            default:      d = DEST_NONE;
        endcase
        return d;
    endfunction

    // value * 10 + digit, kept to 7 bits
    function automatic logic [VAL_W-1:0] shift_in(input logic [VAL_W-1:0] v,
                                                  input logic [3:0] d);
        logic [VAL_W+3:0] p;
        p = {4'b0, v} * 11'd10 + {7'b0, d};
        return p[VAL_W-1:0];
    endfunction

endpackage

### rtl/datetime_string_validator_top.sv
// ----------------------------------------------------------------------------
// datetime_string_validator_top - streaming datetime string checker
// Checks YYYY-MM-DD[ ...][HH:MM:SS[...][ffffff]] one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one character per word, s_tlast marks the final character of
//   a string. m_ channel: one verdict word per string (is_valid, error_code).
//   cfg_ channel: writes fraction_scale (digits of fraction that may be
//   nonzero); cfg_ready is always high. Write it only while the block is idle.
// Path: a final character moves from the input register into the result
//   register, which holds the verdict shown on m_.
// Throughput: one character per cycle unless a final character waits for the
//   result register; the parse update between the input register and the
//   string state / result register is combinational. Stalls: while a verdict
//   waits in the result register, non-final characters keep flowing; a second
//   final character waits in the input register and s_tready drops until
//   m_tready takes the pending verdict. Reset: aresetn low (synchronous)
//   empties both registers, clears the string state and sets fraction_scale to 6.
// ----------------------------------------------------------------------------
module datetime_string_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    // character stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] char_in
    input  logic       s_tlast,     // last_char
    // verdict stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [0] is_valid, [3:1] error_code, [7:4] zero
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data     // fraction_scale
);
    import dsv_pkg::*;

    // config register
    logic [SCALE_W-1:0] scale_reg;

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    // per-string state
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic             fail_reg,  fail_next;
    logic [VAL_W-1:0] month_reg, month_next;
    logic [VAL_W-1:0] day_reg,   day_next;
    logic [VAL_W-1:0] hour_reg,  hour_next;
    logic [VAL_W-1:0] min_reg,   min_next;
    logic [VAL_W-1:0] sec_reg,   sec_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             excess_reg, excess_next;

    // result register
    logic     out_valid_reg;
    dsv_err_t code_reg;
    dsv_err_t code_next;

    logic out_free;
    logic advance;

    assign out_free  = !out_valid_reg || m_tready;
    // a final character may only move on when the result slot is free
    assign advance   = in_valid_reg && (!last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, code_reg, (code_reg == ERR_OK)};

    // parse one character and judge the string as it then stands
    always_comb begin
        logic              stop;
        logic              digit;
        logic [3:0]        d;
        logic [CHAR_W-1:0] sep;
        logic [CNT_W-1:0]  eff;
        logic              has_time;

        pos_next    = pos_reg;
        fail_next   = fail_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        cnt_next    = cnt_reg;
        excess_next = excess_reg;
        stop        = 1'b0;
        digit       = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
        d           = digit ? char_reg[3:0] : 4'd0;
        sep         = sep_at(pos_next);
        eff         = (scale_reg > MAX_FRAC) ? MAX_FRAC : scale_reg;

        if (!fail_reg) begin
            if (pos_next == POS_SPACES) begin
                if (char_reg == CH_SPACE) begin
                    stop = 1'b1;
                end else begin
                    pos_next = POS_TIME_FIRST;
                end
            end
            if (!stop && pos_next == POS_DOTS) begin
                if (char_reg == CH_DOT) begin
                    stop = 1'b1;
                end else begin
                    pos_next = POS_FRAC;
                end
            end
            if (!stop) begin
                if (pos_next == POS_FRAC) begin
                    if (!digit || cnt_reg >= MAX_FRAC) begin
                        fail_next = 1'b1;
                    end else begin
                        if (cnt_reg >= eff && d != 4'd0) begin
                            excess_next = 1'b1;
                        end
                        cnt_next = cnt_reg + 3'd1;
                    end
                end else if (pos_next > POS_TIME_LAST) begin
                    fail_next = 1'b1;
                end else begin
                    sep = sep_at(pos_next);
                    if (sep != CH_DIGIT) begin
                        if (char_reg != sep) begin
                            fail_next = 1'b1;
                        end else begin
                            pos_next = pos_next + 5'd1;
                        end
                    end else if (!digit) begin
                        fail_next = 1'b1;
                    end else begin
                        case (dest_at(pos_next))
                            DEST_MONTH:  month_next = shift_in(month_reg, d);
                            DEST_DAY:    day_next   = shift_in(day_reg, d);
                            DEST_HOUR:   hour_next  = shift_in(hour_reg, d);
                            DEST_MINUTE: min_next   = shift_in(min_reg, d);
                            DEST_SECOND: sec_next   = shift_in(sec_reg, d);
                            default:     ;
                        endcase
                        pos_next = pos_next + 5'd1;
                    end
                end
            end
        end

        // verdict, first failing check wins
        has_time = (pos_next >= POS_DOTS);
        if (fail_next) begin
            code_next = ERR_FORMAT;
        end else if (pos_next != POS_SPACES && pos_next < POS_DOTS) begin
            code_next = ERR_FORMAT;   // ended inside date or time
        end else if (pos_next > POS_FRAC) begin
            code_next = ERR_FORMAT;
        end else if (month_next < 7'd1 || month_next > MONTH_MAX) begin
            code_next = ERR_MONTH;
        end else if (day_next < 7'd1 || day_next > DAY_MAX) begin
            code_next = ERR_DAY;
        end else if (has_time && hour_next > HOUR_MAX) begin
            code_next = ERR_HOUR;
        end else if (has_time && min_next > MINSEC_MAX) begin
            code_next = ERR_MINUTE;
        end else if (has_time && sec_next > MINSEC_MAX) begin
            code_next = ERR_SECOND;
        end else if (has_time && excess_next) begin
            code_next = ERR_FRACTION;
        end else begin
            code_next = ERR_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            fail_reg      <= 1'b0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            cnt_reg       <= '0;
            excess_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                scale_reg <= cfg_data;
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                char_reg     <= s_tdata;
                last_reg     <= s_tlast;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance && last_reg) begin
                out_valid_reg <= 1'b1;
                code_reg      <= code_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (last_reg) begin
                    // verdict given, start the next string fresh
                    pos_reg    <= '0;
                    fail_reg   <= 1'b0;
                    month_reg  <= '0;
                    day_reg    <= '0;
                    hour_reg   <= '0;
                    min_reg    <= '0;
                    sec_reg    <= '0;
                    cnt_reg    <= '0;
                    excess_reg <= 1'b0;
                end else begin
                    pos_reg    <= pos_next;
                    fail_reg   <= fail_next;
                    month_reg  <= month_next;
                    day_reg    <= day_next;
                    hour_reg   <= hour_next;
                    min_reg    <= min_next;
                    sec_reg    <= sec_next;
                    cnt_reg    <= cnt_next;
                    excess_reg <= excess_next;
                end
            end
        end
    end

    // verdict word is consistent: valid exactly when the code is ok
    a_valid_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ERR_OK)))
        else $error("is_valid disagrees with error_code");

    // parse position never runs past the fraction digits
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_FRAC)
        else $error("parse position out of range");

    // at most six fraction digits are ever counted
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_FRAC)
        else $error("fraction digit count out of range");

    // a final character clears the string state and raises a verdict
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> (pos_reg == 5'd0 && !fail_reg && out_valid_reg))
        else $error("string state not cleared after verdict");

endmodule
